// ===== hw/rtl/krte_pkg.sv =====
// Shared types for the keyed record table engine.
// Holds the command and status codes, the record layout and the control word
// that drives the record cells. No dependencies.
package krte_pkg;

   typedef enum logic [2:0] {
      CMD_INSERT = 3'd0,
      CMD_SEARCH = 3'd1,
      CMD_SET    = 3'd2,
      CMD_SOFT   = 3'd3,
      CMD_HARD   = 3'd4,
      CMD_SORT   = 3'd5,
      CMD_READ   = 3'd6,
      CMD_CLEAR  = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_INDEX     = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0] code;
      logic [23:0] price;
      logic        deleted;
   } record_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_WRITE,
      CELL_ROTATE,
      CELL_DROP,
      CELL_SORT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        phase;
      record_type  wdata;
   } cell_ctrl_type;

endpackage

// ===== hw/rtl/krte_cell.sv =====
// One storage cell of the record chain: holds a single record slot.
// Depends on krte_pkg for the record layout and the control word.
module krte_cell #(
   parameter int DEPTH = 16,
   parameter int INDEX = 0,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                   clock,
   input  krte_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0]       target,
   input  logic [CNT_W-1:0]       count,
   input  krte_pkg::record_type   left_rec,
   input  krte_pkg::record_type   right_rec,
   output krte_pkg::record_type   rec
);

   localparam logic [IDX_W-1:0] SELF_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] SELF_POS = CNT_W'(INDEX);
   localparam logic [CNT_W:0]   NEXT_POS = (CNT_W + 1)'(INDEX + 1);
   localparam logic             SELF_PAR = 1'(INDEX % 2);
   localparam logic             HAS_LEFT = (INDEX > 0);

   krte_pkg::record_type rec_ff;
   krte_pkg::record_type rec_in;
   logic                 left_role;
   logic                 right_role;

   // In a sort step this cell pairs with its right neighbor when its parity
   // matches the phase, otherwise with its left neighbor. Only pairs that lie
   // fully inside the held records take part.
   assign left_role  = (SELF_PAR == ctrl.phase) && (NEXT_POS < {1'b0, count});
   assign right_role = HAS_LEFT && (SELF_PAR != ctrl.phase) && (SELF_POS < count);

   always_comb begin
      rec_in = rec_ff;
      case (ctrl.op)
         krte_pkg::CELL_WRITE: begin
            if (target == SELF_IDX) begin
               rec_in = ctrl.wdata;
            end
         end
         krte_pkg::CELL_ROTATE: begin
            rec_in = right_rec;
         end
         krte_pkg::CELL_DROP: begin
            if (SELF_IDX >= target) begin
               rec_in = right_rec;
            end
         end
         krte_pkg::CELL_SORT: begin
            if (left_role && (rec_ff.price > right_rec.price)) begin
               rec_in = right_rec;
            end else if (right_role && (left_rec.price > rec_ff.price)) begin
               rec_in = left_rec;
            end
         end
         default: begin
            rec_in = rec_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign rec = rec_ff;

endmodule

// ===== hw/rtl/keyed_record_table_engine_core.sv =====
// Keyed record table engine. Records live in a chain of TABLE_DEPTH cells and
// one command word is worked on at a time. Insert, clear and a read beyond the
// count go straight to the response state. Search, set price, soft delete, hard
// delete and read rotate the whole chain once past the head cell, one position
// per cycle; a hard delete that matched then shifts the cells from the match on
// down to close the gap. Sort runs TABLE_DEPTH odd-even transposition steps
// between neighboring cells. The result sits in an output register, so the next
// command word is taken while a finished result still waits.
module keyed_record_table_engine_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // Fields from bit 0: key_code[15:0], new_price[39:16], entry_index[43:40].
   input  logic [47:0] req_tdata,
   // Fields from bit 0: command[2:0].
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // Fields from bit 0: found_index[3:0], record_code[19:4],
   // record_price[43:20], record_deleted[44], entry_count[49:45].
   output logic [55:0] rsp_tdata,
   // Fields from bit 0: status[1:0].
   output logic [1:0]  rsp_tuser
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int RD_W  = (IDX_W > 4) ? IDX_W : 4;
   localparam int CHK_W = (CNT_W > 4) ? CNT_W : 4;
   localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT,
      S_SORT,
      S_RESP
   } state_type;

   state_type            state_ff, state_in;
   krte_pkg::cmd_type    cmd_ff, cmd_in;
   logic [15:0]          key_ff, key_in;
   logic [23:0]          price_ff, price_in;
   logic [3:0]           idx_ff, idx_in;
   logic [IDX_W-1:0]     p_ff, p_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pos_ff, pos_in;
   krte_pkg::record_type cap_ff, cap_in;
   logic                 has_rec_ff, has_rec_in;
   krte_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [55:0]          rsp_data_ff, rsp_data_in;
   logic [1:0]           rsp_user_ff, rsp_user_in;

   krte_pkg::cell_ctrl_type cell_ctrl;
   logic [IDX_W-1:0]        cell_target;
   krte_pkg::record_type    rec_q [TABLE_DEPTH];
   krte_pkg::record_type    feed;
   krte_pkg::record_type    head;
   logic                    hit;
   logic                    live;
   logic                    accept;

   assign accept = req_tvalid && req_tready;
   assign head   = rec_q[0];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      price_in     = price_ff;
      idx_in       = idx_ff;
      p_in         = p_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      cap_in       = cap_ff;
      has_rec_in   = has_rec_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      cell_ctrl.op            = krte_pkg::CELL_HOLD;
      cell_ctrl.phase         = p_ff[0];
      cell_ctrl.wdata.code    = req_tdata[15:0];
      cell_ctrl.wdata.price   = req_tdata[39:16];
      cell_ctrl.wdata.deleted = 1'b0;
      cell_target             = pos_ff;

      feed = head;
      hit  = 1'b0;
      live = (CNT_W'(p_ff) < count_ff);

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in     = krte_pkg::cmd_type'(req_tuser);
               key_in     = req_tdata[15:0];
               price_in   = req_tdata[39:16];
               idx_in     = req_tdata[43:40];
               p_in       = '0;
               found_in   = 1'b0;
               pos_in     = '0;
               has_rec_in = 1'b0;
               status_in  = krte_pkg::ST_OK;
               case (krte_pkg::cmd_type'(req_tuser))
                  krte_pkg::CMD_INSERT: begin
                     if (count_ff == FULL_CNT) begin
                        status_in = krte_pkg::ST_FULL;
                     end else begin
                        cell_ctrl.op = krte_pkg::CELL_WRITE;
                        cell_target  = IDX_W'(count_ff);
                        count_in     = count_ff + CNT_W'(1);
                        pos_in       = IDX_W'(count_ff);
                        cap_in       = cell_ctrl.wdata;
                        has_rec_in   = 1'b1;
                     end
                     state_in = S_RESP;
                  end
                  krte_pkg::CMD_SORT: begin
                     state_in = S_SORT;
                  end
                  krte_pkg::CMD_READ: begin
                     if (CHK_W'(req_tdata[43:40]) >= CHK_W'(count_ff)) begin
                        status_in = krte_pkg::ST_INDEX;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  krte_pkg::CMD_CLEAR: begin
                     count_in = '0;
                     state_in = S_RESP;
                  end
                  default: begin
                     state_in = S_SCAN;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // The record at position p_ff sits in the head cell this cycle.
            cell_ctrl.op = krte_pkg::CELL_ROTATE;
            if (cmd_ff == krte_pkg::CMD_READ) begin
               hit = !found_ff && (RD_W'(p_ff) == RD_W'(idx_ff));
            end else begin
               hit = !found_ff && live && !head.deleted && (head.code == key_ff);
            end
            if (hit) begin
               if (cmd_ff == krte_pkg::CMD_SET) begin
                  feed.price = price_ff;
               end else if (cmd_ff == krte_pkg::CMD_SOFT) begin
                  feed.deleted = 1'b1;
               end
               found_in   = 1'b1;
               pos_in     = p_ff;
               cap_in     = feed;
               has_rec_in = 1'b1;
            end
            p_in = p_ff + IDX_W'(1);
            if (p_ff == LAST_POS) begin
               if ((cmd_ff == krte_pkg::CMD_HARD) && (found_ff || hit)) begin
                  state_in = S_SHIFT;
               end else begin
                  status_in = (found_ff || hit) ? krte_pkg::ST_OK : krte_pkg::ST_NOT_FOUND;
                  state_in  = S_RESP;
               end
            end
         end
         S_SHIFT: begin
            cell_ctrl.op = krte_pkg::CELL_DROP;
            cell_target  = pos_ff;
            count_in     = count_ff - CNT_W'(1);
            status_in    = krte_pkg::ST_OK;
            state_in     = S_RESP;
         end
         S_SORT: begin
            cell_ctrl.op = krte_pkg::CELL_SORT;
            p_in         = p_ff + IDX_W'(1);
            if (p_ff == LAST_POS) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = status_ff;
               if (has_rec_ff) begin
                  rsp_data_in = {6'd0, 5'(count_ff), cap_ff.deleted, cap_ff.price,
                                 cap_ff.code, 4'(pos_ff)};
               end else begin
                  rsp_data_in = {6'd0, 5'(count_ff), 45'd0};
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         has_rec_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         has_rec_ff   <= has_rec_in;
      end
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      price_ff    <= price_in;
      idx_ff      <= idx_in;
      p_ff        <= p_in;
      pos_ff      <= pos_in;
      cap_ff      <= cap_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   generate
      for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         krte_pkg::record_type left_rec;
         krte_pkg::record_type right_rec;
         if (i == 0) begin : g_first
            assign left_rec = rec_q[0];
         end else begin : g_mid_left
            assign left_rec = rec_q[i-1];
         end
         // The tail cell closes the ring with the head record, updated on a set price or soft delete hit.
         if (i == TABLE_DEPTH - 1) begin : g_last
            assign right_rec = feed;
         end else begin : g_mid_right
            assign right_rec = rec_q[i+1];
         end
         krte_cell #(
            .DEPTH(TABLE_DEPTH),
            .INDEX(i)
         ) u_cell (
            .clock    (clock),
            .ctrl     (cell_ctrl),
            .target   (cell_target),
            .count    (count_ff),
            .left_rec (left_rec),
            .right_rec(right_rec),
            .rec      (rec_q[i])
         );
      end
   endgenerate

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef ASSERT_OFF
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == krte_pkg::CMD_INSERT) && (count_ff != FULL_CNT))
      |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not grow the record count");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == krte_pkg::CMD_CLEAR))
      |=> ((count_ff == '0) && (state_ff == S_RESP)))
      else $error("clear did not empty the table");

   a_shift_found: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT)
      |-> (found_ff && (cmd_ff == krte_pkg::CMD_HARD) && (count_ff != '0)))
      else $error("shift without a matched record");

   a_no_record: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_valid_ff && (rsp_user_in != krte_pkg::ST_OK))
      |-> (rsp_data_in[44:0] == '0))
      else $error("failed command reports a record");
`endif

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for keyed_record_table_engine_core: a shadow copy of the record table
// predicts every result word, which is checked field by field against the stream output.
// Depends on krte_pkg and the core module.
`timescale 1ns / 1ps

module tb;

   localparam int TABLE_DEPTH = 16;

   typedef struct {
      krte_pkg::status_type status;
      logic [3:0]           index;
      krte_pkg::record_type rec;
      logic [4:0]           count;
   } table_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   // Fields from bit 0: key_code[15:0], new_price[39:16], entry_index[43:40].
   logic [47:0] req_tdata;
   // Fields from bit 0: command[2:0].
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   // Fields from bit 0: found_index[3:0], record_code[19:4],
   // record_price[43:20], record_deleted[44], entry_count[49:45].
   logic [55:0] rsp_tdata;
   // Fields from bit 0: status[1:0].
   logic [1:0]  rsp_tuser;

   krte_pkg::record_type shadow_table [TABLE_DEPTH];
   int                   shadow_count = 0;
   table_result_type     expected_results [$];
   int                   mismatch_count = 0;
   bit                   req_idle_enable = 1'b1;
   bit                   rsp_idle_enable = 1'b1;
   int                   rsp_holdoff_cycles = 0;

   keyed_record_table_engine_core #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Applies one command to the shadow table and returns the word it should produce.
   function automatic table_result_type apply_table_command(krte_pkg::cmd_type cmd,
                                                            logic [15:0] key,
                                                            logic [23:0] price,
                                                            logic [3:0] idx);
      table_result_type     res;
      krte_pkg::record_type held;
      int                   pos;
      res.status = krte_pkg::ST_OK;
      res.index  = '0;
      res.rec    = '0;
      pos        = -1;
      case (cmd)
         krte_pkg::CMD_INSERT: begin
            if (shadow_count >= TABLE_DEPTH) begin
               res.status = krte_pkg::ST_FULL;
            end else begin
               shadow_table[shadow_count] = '{code: key, price: price, deleted: 1'b0};
               res.index = shadow_count[3:0];
               res.rec   = shadow_table[shadow_count];
               shadow_count++;
            end
         end
         krte_pkg::CMD_SEARCH, krte_pkg::CMD_SET, krte_pkg::CMD_SOFT,
         krte_pkg::CMD_HARD: begin
            for (int i = 0; i < shadow_count; i++) begin
               if (pos < 0 && !shadow_table[i].deleted && shadow_table[i].code == key)
                  pos = i;
            end
            if (pos < 0) begin
               res.status = krte_pkg::ST_NOT_FOUND;
            end else begin
               if (cmd == krte_pkg::CMD_SET)
                  shadow_table[pos].price = price;
               else if (cmd == krte_pkg::CMD_SOFT)
                  shadow_table[pos].deleted = 1'b1;
               res.index = pos[3:0];
               res.rec   = shadow_table[pos];
               if (cmd == krte_pkg::CMD_HARD) begin
                  for (int j = pos; j + 1 < shadow_count; j++)
                     shadow_table[j] = shadow_table[j + 1];
                  shadow_count--;
               end
            end
         end
         krte_pkg::CMD_SORT: begin
            // Strict compare keeps equal prices in their original order.
            for (int i = 0; i + 1 < shadow_count; i++) begin
               for (int j = 0; j + 1 < shadow_count; j++) begin
                  if (shadow_table[j].price > shadow_table[j + 1].price) begin
                     held                = shadow_table[j];
                     shadow_table[j]     = shadow_table[j + 1];
                     shadow_table[j + 1] = held;
                  end
               end
            end
         end
         krte_pkg::CMD_READ: begin
            if (idx >= shadow_count) begin
               res.status = krte_pkg::ST_INDEX;
            end else begin
               res.index = idx;
               res.rec   = shadow_table[idx];
            end
         end
         default: begin
            shadow_count = 0;
         end
      endcase
      res.count = shadow_count[4:0];
      return res;
   endfunction

   task automatic send_command(input krte_pkg::cmd_type cmd, input logic [15:0] key,
                               input logic [23:0] price, input logic [3:0] idx);
      @(negedge clock);
      while (req_idle_enable && $urandom_range(0, 99) < 31) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'd0, idx, price, key};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(apply_table_command(cmd, key, price, idx));
   endtask

   // Keys come mostly from a small pool so that searches and deletes hit.
   task automatic send_random_command();
      krte_pkg::cmd_type cmd;
      logic [15:0]       key;
      logic [23:0]       price;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)      cmd = krte_pkg::CMD_INSERT;
      else if (pick < 45) cmd = krte_pkg::CMD_SEARCH;
      else if (pick < 55) cmd = krte_pkg::CMD_SET;
      else if (pick < 63) cmd = krte_pkg::CMD_SOFT;
      else if (pick < 76) cmd = krte_pkg::CMD_HARD;
      else if (pick < 81) cmd = krte_pkg::CMD_SORT;
      else if (pick < 97) cmd = krte_pkg::CMD_READ;
      else                cmd = krte_pkg::CMD_CLEAR;
      case ($urandom_range(0, 9))
         0:       key = 16'h0000;
         1:       key = 16'hFFFF;
         2:       key = 16'($urandom);
         default: key = 16'h5A00 + 16'($urandom_range(0, 5));
      endcase
      if ($urandom_range(0, 3) == 0)
         price = 24'($urandom_range(0, 3)) * 24'h555555;
      else
         price = 24'($urandom);
      send_command(cmd, key, price, 4'($urandom_range(0, 15)));
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_cases();
      logic [15:0] key;
      logic [23:0] price;
      send_command(krte_pkg::CMD_READ, 16'h0000, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_HARD, 16'h0000, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_SORT, 16'hFFFF, 24'hFFFFFF, 4'd15);
      // Fill the table: duplicate keys at every fourth slot, ties on price.
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (i == 3)         key = 16'h0000;
         else if (i % 4 == 2) key = 16'h1234;
         else                key = 16'hFFFF - 16'(i);
         if (i % 3 == 0)     price = 24'd500;
         else if (i == 1)    price = 24'hFFFFFF;
         else if (i == 4)    price = 24'h000000;
         else                price = 24'hFFFFFF - 24'(i) * 24'd999_999;
         send_command(krte_pkg::CMD_INSERT, key, price, 4'($urandom_range(0, 15)));
      end
      send_command(krte_pkg::CMD_INSERT, 16'hBEEF, 24'h123456, 4'd0);
      send_command(krte_pkg::CMD_READ, 16'h0000, 24'h000000, 4'd15);
      send_command(krte_pkg::CMD_SEARCH, 16'h1234, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_SOFT, 16'h1234, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_SET, 16'h1234, 24'd7, 4'd0);
      send_command(krte_pkg::CMD_HARD, 16'h0BAD, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_HARD, 16'hFFFF, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_READ, 16'h0000, 24'h000000, 4'd15);
      send_command(krte_pkg::CMD_SORT, 16'h0000, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_READ, 16'h0000, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_CLEAR, 16'h0000, 24'h000000, 4'd0);
      send_command(krte_pkg::CMD_READ, 16'h0000, 24'h000000, 4'd0);
      pause_until_drained();
   endtask

   task automatic test_random_traffic(input int count);
      for (int n = 0; n < count; n++)
         send_random_command();
      pause_until_drained();
   endtask

   // The receiver stops for a long stretch so the core fills and stalls its input.
   task automatic test_output_backpressure();
      rsp_holdoff_cycles = 300;
      for (int n = 0; n < 40; n++)
         send_random_command();
      pause_until_drained();
   endtask

   task automatic test_full_rate_stretch(input int count);
      req_idle_enable = 1'b0;
      rsp_idle_enable = 1'b0;
      for (int n = 0; n < count; n++)
         send_random_command();
      pause_until_drained();
      req_idle_enable = 1'b1;
      rsp_idle_enable = 1'b1;
   endtask

   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_holdoff_cycles > 0) begin
            rsp_holdoff_cycles = rsp_holdoff_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(rsp_idle_enable && $urandom_range(0, 99) < 31);
         end
      end
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t ns: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result word tuser=%h tdata=%h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[3:0] !== want.index ||
                rsp_tdata[19:4] !== want.rec.code || rsp_tdata[43:20] !== want.rec.price ||
                rsp_tdata[44] !== want.rec.deleted || rsp_tdata[49:45] !== want.count ||
                rsp_tdata[55:50] !== 6'd0)
               report_mismatch({
                  $sformatf("expected st=%0d idx=%0d code=%h price=%h del=%b cnt=%0d, ",
                            want.status, want.index, want.rec.code, want.rec.price,
                            want.rec.deleted, want.count),
                  $sformatf("got st=%0d idx=%0d code=%h price=%h del=%b cnt=%0d pad=%h",
                            rsp_tuser, rsp_tdata[3:0], rsp_tdata[19:4], rsp_tdata[43:20],
                            rsp_tdata[44], rsp_tdata[49:45], rsp_tdata[55:50])});
         end
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = krte_pkg::CMD_INSERT;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_traffic(500);
      test_output_backpressure();
      test_full_rate_stretch(200);
      test_random_traffic(310);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
